@@ hdl/slotted_page_record_store_top_defines.svh @@
// Assertion macros for the slotted page record store.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef SLOTTED_PAGE_RECORD_STORE_TOP_DEFINES_SVH
`define SLOTTED_PAGE_RECORD_STORE_TOP_DEFINES_SVH

// same-cycle implication, gated off in reset
`define SPR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spr check failed");

// next-cycle implication, gated off in reset
`define SPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spr check failed");

`endif

@@ hdl/spr_pkg.sv @@
// Shared types, codes and default sizes of the slotted page record store.
// No dependencies.
package spr_pkg;

   localparam int PAGE_BYTES_DEF   = 4096;
   localparam int MAX_SLOTS_DEF    = 1024;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int SLOT_BYTES_DEF   = 3;
   localparam int MAX_RECORD       = 255;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [1:0] OP_FORMAT = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_REC  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       eor;
      logic [9:0] rec;
      logic       rec_zero;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  record_count;
      logic [12:0] free_data_top;
      logic [63:0] read_word;
      logic [3:0]  read_bytes;
      logic        last_result;
   } rsp_type;

endpackage

@@ hdl/spr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ hdl/spr_fifo.sv @@
// Small register FIFO used for the command and result queues.
// No dependencies.
module spr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= wdata;
      end
   end

endmodule

@@ hdl/spr_front.sv @@
// Front end: takes request words, decodes them and queues them for the back end.
// Depends on spr_pkg and spr_fifo.
module spr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [1:0]       req_command,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_record,
   input  logic [9:0]       req_record_number,
   input  logic             cmd_pop,
   output spr_pkg::cmd_type cmd_head,
   output logic             cmd_empty
);

   spr_pkg::cmd_type cmd_new;
   logic [$bits(spr_pkg::cmd_type)-1:0] head_vec;

   always_comb begin
      cmd_new           = '0;
      cmd_new.op        = req_command;
      cmd_new.rec       = req_record_number;
      cmd_new.rec_zero  = (req_record_number == '0);
      unique case (req_command)
         spr_pkg::OP_ADD: begin
            cmd_new.data_byte = req_data_byte;
            cmd_new.eor       = req_end_of_record;
         end
         default: begin
            cmd_new.data_byte = '0;
            cmd_new.eor       = 1'b0;
         end
      endcase
   end

   spr_fifo #(
      .WIDTH($bits(spr_pkg::cmd_type)),
      .DEPTH(spr_pkg::QUEUE_DEPTH)
   ) u_cmdq (
      .clock(clock),
      .reset(reset),
      .push (push),
      .wdata(cmd_new),
      .full (full),
      .pop  (cmd_pop),
      .rdata(head_vec),
      .empty(cmd_empty)
   );

   assign cmd_head = spr_pkg::cmd_type'(head_vec);

endmodule

@@ hdl/spr_back.sv @@
// Back end: executes queued commands against the page, slot and staging RAMs.
// Depends on spr_pkg, spr_ram and the assertion macro header.
`include "slotted_page_record_store_top_defines.svh"
module spr_back #(
   parameter int PAGE_BYTES   = spr_pkg::PAGE_BYTES_DEF,
   parameter int MAX_SLOTS    = spr_pkg::MAX_SLOTS_DEF,
   parameter int HEADER_BYTES = spr_pkg::HEADER_BYTES_DEF,
   parameter int SLOT_BYTES   = spr_pkg::SLOT_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  spr_pkg::cmd_type cmd_head,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output spr_pkg::rsp_type rsp_data
);

   localparam int PA_W   = $clog2(PAGE_BYTES);
   localparam int TOP_W  = $clog2(PAGE_BYTES + 1);
   localparam int SA_W   = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int RW     = (CNT_W > 10) ? CNT_W : 10;
   localparam int NEED_W = $clog2(HEADER_BYTES + (MAX_SLOTS + 1) * SLOT_BYTES
                                  + PAGE_BYTES + 257);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CP_RD   = 4'd1;
   localparam logic [3:0] S_CP_WR   = 4'd2;
   localparam logic [3:0] S_RM_SLOT = 4'd3;
   localparam logic [3:0] S_MV_RD   = 4'd4;
   localparam logic [3:0] S_MV_WR   = 4'd5;
   localparam logic [3:0] S_SH_RD   = 4'd6;
   localparam logic [3:0] S_SH_WR   = 4'd7;
   localparam logic [3:0] S_RD_SLOT = 4'd8;
   localparam logic [3:0] S_RD_RD   = 4'd9;
   localparam logic [3:0] S_RD_CAP  = 4'd10;
   localparam logic [3:0] S_RD_EMIT = 4'd11;
   localparam logic [3:0] S_FIN     = 4'd12;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TOP_W-1:0] top_ff, top_in;
   logic [8:0]       stage_cnt_ff, stage_cnt_in;
   logic [7:0]       len_ff, len_in;
   logic [PA_W-1:0]  base_ff, base_in;
   logic [7:0]       j_ff, j_in;
   logic [PA_W-1:0]  a_ff, a_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [PA_W-1:0]  pos_ff, pos_in;
   logic [7:0]       left_ff, left_in;
   logic [3:0]       bcnt_ff, bcnt_in;
   logic [63:0]      word_ff, word_in;
   logic [1:0]       status_ff, status_in;

   // RAM ports
   logic              pg_we;
   logic [PA_W-1:0]   pg_waddr, pg_raddr;
   logic [7:0]        pg_wdata, pg_rdata;
   logic              sl_we;
   logic [SA_W-1:0]   sl_waddr, sl_raddr;
   logic [PA_W+7:0]   sl_wdata, sl_rdata;
   logic              stg_we;
   logic [7:0]        stg_waddr, stg_raddr, stg_wdata, stg_rdata;

   logic [RW-1:0]     rec_x;
   logic              rec_ok;
   logic [8:0]        stage_new;
   logic [NEED_W-1:0] need;
   logic [PA_W-1:0]   sl_off;
   logic [7:0]        sl_len;
   logic [TOP_W:0]    top_sum;
   logic [1:0]        push_status;
   logic              push_rd;
   logic              push_last;

   assign rec_x     = RW'(cmd_head.rec);
   assign rec_ok    = !cmd_head.rec_zero && (rec_x <= RW'(count_ff));
   assign stage_new = stage_cnt_ff[8] ? stage_cnt_ff : stage_cnt_ff + 9'd1;
   assign need      = NEED_W'(HEADER_BYTES)
                      + NEED_W'(count_ff + 1'b1) * NEED_W'(SLOT_BYTES);
   assign sl_off    = sl_rdata[PA_W+7:8];
   assign sl_len    = sl_rdata[7:0];
   assign top_sum   = (TOP_W+1)'(top_ff) + (TOP_W+1)'(len_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      stage_cnt_in = stage_cnt_ff;
      len_in       = len_ff;
      base_in      = base_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      i_in         = i_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      bcnt_in      = bcnt_ff;
      word_in      = word_ff;
      status_in    = status_ff;
      pg_we        = 1'b0;
      pg_waddr     = '0;
      pg_wdata     = '0;
      pg_raddr     = '0;
      sl_we        = 1'b0;
      sl_waddr     = '0;
      sl_wdata     = '0;
      sl_raddr     = '0;
      stg_we       = 1'b0;
      stg_waddr    = stage_cnt_ff[7:0];
      stg_wdata    = cmd_head.data_byte;
      stg_raddr    = j_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      push_status  = spr_pkg::ST_OK;
      push_rd      = 1'b0;
      push_last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop  = 1'b1;
               sl_raddr = SA_W'(rec_x - 1'b1);
               unique case (cmd_head.op)
                  spr_pkg::OP_FORMAT: begin
                     count_in     = '0;
                     top_in       = TOP_W'(PAGE_BYTES);
                     stage_cnt_in = '0;
                     rsp_push     = 1'b1;
                  end
                  spr_pkg::OP_ADD: begin
                     stg_we       = !stage_cnt_ff[8];
                     stage_cnt_in = stage_new;
                     if (!cmd_head.eor) begin
                        rsp_push = 1'b1;
                     end else begin
                        stage_cnt_in = '0;
                        if (stage_new[8]) begin
                           rsp_push    = 1'b1;
                           push_status = spr_pkg::ST_TOO_LONG;
                        end else if (count_ff >= CNT_W'(MAX_SLOTS) ||
                                     need + NEED_W'(stage_new) >= NEED_W'(top_ff)) begin
                           rsp_push    = 1'b1;
                           push_status = spr_pkg::ST_FULL;
                        end else begin
                           len_in   = stage_new[7:0];
                           base_in  = PA_W'(top_ff - TOP_W'(stage_new));
                           j_in     = '0;
                           state_in = S_CP_RD;
                        end
                     end
                  end
                  spr_pkg::OP_REMOVE: begin
                     if (!rec_ok) begin
                        rsp_push    = 1'b1;
                        push_status = spr_pkg::ST_BAD_REC;
                     end else begin
                        i_in     = CNT_W'(rec_x - 1'b1);
                        state_in = S_RM_SLOT;
                     end
                  end
                  default: begin
                     if (!rec_ok) begin
                        rsp_push    = 1'b1;
                        push_status = spr_pkg::ST_BAD_REC;
                     end else begin
                        state_in = S_RD_SLOT;
                     end
                  end
               endcase
            end
         end
         // commit: copy staged bytes below the old data top
         S_CP_RD: begin
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            pg_we    = 1'b1;
            pg_waddr = base_ff + PA_W'(j_ff);
            pg_wdata = stg_rdata;
            j_in     = j_ff + 8'd1;
            state_in = S_CP_RD;
            if (j_ff == len_ff - 8'd1) begin
               sl_we     = 1'b1;
               sl_waddr  = count_ff[SA_W-1:0];
               sl_wdata  = {base_ff, len_ff};
               count_in  = count_ff + 1'b1;
               top_in    = TOP_W'(base_ff);
               status_in = spr_pkg::ST_OK;
               state_in  = S_FIN;
            end
         end
         S_RM_SLOT: begin
            a_in     = sl_off;
            base_in  = sl_off;
            len_in   = sl_len;
            state_in = S_MV_RD;
         end
         // move data beneath the removed record up, highest byte first
         S_MV_RD: begin
            if (TOP_W'(a_ff) == top_ff) begin
               state_in = S_SH_RD;
            end else begin
               pg_raddr = a_ff - 1'b1;
               a_in     = a_ff - 1'b1;
               state_in = S_MV_WR;
            end
         end
         S_MV_WR: begin
            pg_we    = 1'b1;
            pg_waddr = a_ff + PA_W'(len_ff);
            pg_wdata = pg_rdata;
            state_in = S_MV_RD;
         end
         // close the gap in the slot directory
         S_SH_RD: begin
            if (i_ff + 1'b1 < count_ff) begin
               sl_raddr = SA_W'(i_ff + 1'b1);
               state_in = S_SH_WR;
            end else begin
               count_in  = count_ff - 1'b1;
               top_in    = (top_sum > (TOP_W+1)'(PAGE_BYTES)) ?
                           TOP_W'(PAGE_BYTES) : top_sum[TOP_W-1:0];
               status_in = spr_pkg::ST_OK;
               state_in  = S_FIN;
            end
         end
         S_SH_WR: begin
            sl_we    = 1'b1;
            sl_waddr = i_ff[SA_W-1:0];
            sl_wdata = {sl_off + PA_W'(len_ff), sl_len};
            i_in     = i_ff + 1'b1;
            state_in = S_SH_RD;
         end
         S_RD_SLOT: begin
            pos_in  = sl_off;
            left_in = sl_len;
            bcnt_in = '0;
            word_in = '0;
            if (sl_len == '0) begin
               status_in = spr_pkg::ST_OK;
               state_in  = S_FIN;
            end else begin
               state_in = S_RD_RD;
            end
         end
         S_RD_RD: begin
            pg_raddr = pos_ff;
            state_in = S_RD_CAP;
         end
         S_RD_CAP: begin
            word_in[{bcnt_ff[2:0], 3'b000} +: 8] = pg_rdata;
            bcnt_in = bcnt_ff + 4'd1;
            left_in = left_ff - 8'd1;
            pos_in  = pos_ff + 1'b1;
            state_in = (bcnt_ff == 4'd7 || left_ff == 8'd1) ? S_RD_EMIT : S_RD_RD;
         end
         S_RD_EMIT: begin
            if (!rsp_full) begin
               rsp_push  = 1'b1;
               push_rd   = 1'b1;
               push_last = (left_ff == '0);
               word_in   = '0;
               bcnt_in   = '0;
               state_in  = (left_ff == '0) ? S_IDLE : S_RD_RD;
            end
         end
         S_FIN: begin
            if (!rsp_full) begin
               rsp_push    = 1'b1;
               push_status = status_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data               = '0;
      rsp_data.status        = push_status;
      rsp_data.record_count  = 10'(count_in);
      rsp_data.free_data_top = 13'(top_in);
      rsp_data.read_word     = push_rd ? word_ff : '0;
      rsp_data.read_bytes    = push_rd ? bcnt_ff : '0;
      rsp_data.last_result   = push_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= TOP_W'(PAGE_BYTES);
         stage_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         stage_cnt_ff <= stage_cnt_in;
      end
      len_ff    <= len_in;
      base_ff   <= base_in;
      j_ff      <= j_in;
      a_ff      <= a_in;
      i_ff      <= i_in;
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      bcnt_ff   <= bcnt_in;
      word_ff   <= word_in;
      status_ff <= status_in;
   end

   spr_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
      .clock(clock), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
      .raddr(pg_raddr), .rdata(pg_rdata)
   );

   spr_ram #(.WIDTH(PA_W + 8), .DEPTH(MAX_SLOTS)) u_slot (
      .clock(clock), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
      .raddr(sl_raddr), .rdata(sl_rdata)
   );

   spr_ram #(.WIDTH(8), .DEPTH(spr_pkg::MAX_RECORD + 1)) u_stage (
      .clock(clock), .we(stg_we), .waddr(stg_waddr), .wdata(stg_wdata),
      .raddr(stg_raddr), .rdata(stg_rdata)
   );

   `SPR_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_SLOTS))
   `SPR_ASSERT_IMPL(a_top_max, clock, reset, 1'b1, top_ff <= TOP_W'(PAGE_BYTES))
   `SPR_ASSERT_IMPL(a_no_push_full, clock, reset, rsp_push, !rsp_full)
   `SPR_ASSERT_IMPL(a_word_nonempty, clock, reset, push_rd, bcnt_ff != '0)
   `SPR_ASSERT_NEXT(a_commit_fin, clock, reset, sl_we && state_ff == S_CP_WR,
                    state_ff == S_FIN)

endmodule

@@ hdl/slotted_page_record_store_top.sv @@
// Top level of the slotted page record store.
// Depends on spr_pkg, spr_front, spr_back and spr_fifo.
//
// channel   direction  handshake            payload
// request   in         push / full          req_command, req_data_byte,
//                                           req_end_of_record, req_record_number
// response  out        pop / empty          rsp_status, rsp_record_count,
//                                           rsp_free_data_top, rsp_read_word,
//                                           rsp_read_bytes, rsp_last_result
//
// Format, add byte and rejected commands are answered directly from the idle state.
// Commit: a staging read then a page write per byte, one page RAM port.
// Read: a page read, then a capture per byte; an emit per word.
// Remove: a read and a write per byte lying beneath the record and per later slot.
// Reset is synchronous; the page, slot and staging RAMs are not cleared.
// Either side may stall; a two-word queue on each side decouples them.
module slotted_page_record_store_top #(
   parameter int PAGE_BYTES   = spr_pkg::PAGE_BYTES_DEF,
   parameter int MAX_SLOTS    = spr_pkg::MAX_SLOTS_DEF,
   parameter int HEADER_BYTES = spr_pkg::HEADER_BYTES_DEF,
   parameter int SLOT_BYTES   = spr_pkg::SLOT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_record,
   input  logic [9:0]  req_record_number,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_record_count,
   output logic [12:0] rsp_free_data_top,
   output logic [63:0] rsp_read_word,
   output logic [3:0]  rsp_read_bytes,
   output logic        rsp_last_result
);

   spr_pkg::cmd_type cmd_head;
   logic             cmd_empty, cmd_pop;
   spr_pkg::rsp_type rsp_new, rsp_head;
   logic             rsp_push, rsp_full;
   logic [$bits(spr_pkg::rsp_type)-1:0] rsp_vec;

   // front: decode and queue request words
   spr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .req_end_of_record(req_end_of_record),
      .req_record_number(req_record_number),
      .cmd_pop          (cmd_pop),
      .cmd_head         (cmd_head),
      .cmd_empty        (cmd_empty)
   );

   // back: sequencer over page, slot and staging RAMs
   spr_back #(
      .PAGE_BYTES  (PAGE_BYTES),
      .MAX_SLOTS   (MAX_SLOTS),
      .HEADER_BYTES(HEADER_BYTES),
      .SLOT_BYTES  (SLOT_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_data (rsp_new)
   );

   // result queue: the oldest word sits on the rsp_ ports
   spr_fifo #(
      .WIDTH($bits(spr_pkg::rsp_type)),
      .DEPTH(spr_pkg::QUEUE_DEPTH)
   ) u_rspq (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .wdata(rsp_new),
      .full (rsp_full),
      .pop  (pop),
      .rdata(rsp_vec),
      .empty(empty)
   );

   assign rsp_head          = spr_pkg::rsp_type'(rsp_vec);
   assign rsp_status        = rsp_head.status;
   assign rsp_record_count  = rsp_head.record_count;
   assign rsp_free_data_top = rsp_head.free_data_top;
   assign rsp_read_word     = rsp_head.read_word;
   assign rsp_read_bytes    = rsp_head.read_bytes;
   assign rsp_last_result   = rsp_head.last_result;

endmodule
